// ----- sv/rowm_pkg.sv -----
`default_nettype none

package rowm_pkg;

   // Width of the position, score and count fields on the streams.
   localparam int FIELD_W = 32;
   // Default number of position bits kept from pos_start and pos_end.
   localparam int POSITION_BITS_DEF = 32;
   // Entries in the queue between the front and the back.
   localparam int QUEUE_DEPTH = 2;

   // Input opcodes, carried on req_tuser. Code 3 means nothing.
   typedef enum logic [1:0] {
      OP_START  = 2'd0,
      OP_BIN    = 2'd1,
      OP_FINISH = 2'd2
   } opcode_type;

   // Work kinds handed from the front to the back.
   typedef enum logic [1:0] {
      KIND_START  = 2'd0,
      KIND_BIN    = 2'd1,
      KIND_FINISH = 2'd2
   } kind_type;

   // One queued work entry. For a bin, amount is the overlap in bases; for a
   // finish, it is the frame length.
   typedef struct packed {
      kind_type           kind;
      logic [FIELD_W:0]   amount;
      logic signed [FIELD_W-1:0] score;
      logic               skip;
      logic               bad_frame;
   } entry_type;

   // Status of the back, for checking.
   typedef struct packed {
      logic dividing;
      logic finishing;
   } back_status_type;

endpackage

`default_nettype wire

// ----- sv/rowm_front.sv -----
`default_nettype none

module rowm_front #(
   parameter int POSITION_BITS = rowm_pkg::POSITION_BITS_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   input  wire logic [3*rowm_pkg::FIELD_W-1:0] req_tdata,
   input  wire logic [1:0]                  req_tuser,
   input  wire logic                        ignore_negative,
   output logic                             q_push,
   output rowm_pkg::entry_type              q_entry,
   input  wire logic                        q_full
);

   localparam int FW    = rowm_pkg::FIELD_W;
   localparam int POS_W = (POSITION_BITS < FW) ? POSITION_BITS : FW;

   // Stage register holding the beat being classified.
   logic                     stg_valid_ff, stg_valid_in;
   rowm_pkg::opcode_type     stg_op_ff;
   logic [POS_W-1:0]         stg_a_ff;
   logic [POS_W-1:0]         stg_b_ff;
   logic signed [FW-1:0]     stg_score_ff;

   // Current frame, closed and 1-based.
   logic [POS_W-1:0]         frame_first_ff, frame_first_in;
   logic [POS_W-1:0]         frame_last_ff, frame_last_in;

   logic [FW:0]              bin_lo;
   logic [FW:0]              bin_hi;
   logic [FW:0]              start_plus_one;
   logic                     bin_hit;
   logic                     need_push;
   logic                     advance;
   logic                     take;

   // Clamp the bin to the frame and measure the shared bases.
   always_comb begin
      start_plus_one = (FW+1)'(stg_a_ff) + (FW+1)'(1);
      bin_lo = (start_plus_one < (FW+1)'(frame_first_ff)) ?
               (FW+1)'(frame_first_ff) : start_plus_one;
      bin_hi = (stg_b_ff > frame_last_ff) ? (FW+1)'(frame_last_ff) : (FW+1)'(stg_b_ff);
      bin_hit = (bin_hi >= bin_lo);
   end

   // Build the queue entry for the beat in the stage.
   always_comb begin
      q_entry           = '0;
      q_entry.score     = stg_score_ff;
      q_entry.skip      = ignore_negative && (stg_score_ff[FW-1] || (stg_score_ff == '0));
      q_entry.bad_frame = (frame_last_ff < frame_first_ff);
      need_push         = 1'b0;
      case (stg_op_ff)
         rowm_pkg::OP_START: begin
            q_entry.kind = rowm_pkg::KIND_START;
            need_push    = 1'b1;
         end
         rowm_pkg::OP_BIN: begin
            q_entry.kind   = rowm_pkg::KIND_BIN;
            q_entry.amount = bin_hi - bin_lo + (FW+1)'(1);
            need_push      = bin_hit;
         end
         rowm_pkg::OP_FINISH: begin
            q_entry.kind   = rowm_pkg::KIND_FINISH;
            q_entry.amount = (FW+1)'(frame_last_ff) - (FW+1)'(frame_first_ff) + (FW+1)'(1);
            need_push      = 1'b1;
         end
         default: begin
            q_entry.kind = rowm_pkg::KIND_START;
            need_push    = 1'b0;
         end
      endcase
   end

   // The stage empties when its entry is queued or dropped.
   always_comb begin
      advance      = stg_valid_ff && (!need_push || !q_full);
      q_push       = stg_valid_ff && need_push && !q_full;
      req_tready   = !stg_valid_ff || advance;
      take         = req_tvalid && req_tready;
      stg_valid_in = take ? 1'b1 : (advance ? 1'b0 : stg_valid_ff);
   end

   // A start beat sets the frame as it leaves the stage.
   always_comb begin
      frame_first_in = frame_first_ff;
      frame_last_in  = frame_last_ff;
      if (advance && (stg_op_ff == rowm_pkg::OP_START)) begin
         frame_first_in = stg_a_ff;
         frame_last_in  = stg_b_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff   <= 1'b0;
         frame_first_ff <= '0;
         frame_last_ff  <= '0;
      end else begin
         stg_valid_ff   <= stg_valid_in;
         frame_first_ff <= frame_first_in;
         frame_last_ff  <= frame_last_in;
      end
   end

   // Stage payload.
   always_ff @(posedge clock) begin
      if (take) begin
         stg_op_ff    <= rowm_pkg::opcode_type'(req_tuser);
         stg_a_ff     <= req_tdata[POS_W-1:0];
         stg_b_ff     <= req_tdata[FW+POS_W-1:FW];
         stg_score_ff <= req_tdata[3*FW-1:2*FW];
      end
   end

endmodule

`default_nettype wire

// ----- sv/rowm_queue.sv -----
`default_nettype none

module rowm_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire rowm_pkg::entry_type push_entry,
   output logic                     full,
   input  wire logic                pop,
   output rowm_pkg::entry_type      head,
   output logic                     empty
);

   localparam int DEPTH = rowm_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   rowm_pkg::entry_type entries_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                do_push;
   logic                do_pop;

   // Pointer and fill count update.
   always_comb begin
      full      = (count_ff == CNT_W'(DEPTH));
      empty     = (count_ff == '0);
      do_push   = push && !full;
      do_pop    = pop && !empty;
      head      = entries_ff[rd_ptr_ff];
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

// ----- sv/rowm_back.sv -----
`default_nettype none

module rowm_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire rowm_pkg::entry_type head,
   input  wire logic                empty,
   output logic                     pop,
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output logic [3*rowm_pkg::FIELD_W-1:0] rsp_tdata,
   output logic                     rsp_tuser,
   output rowm_pkg::back_status_type status
);

   localparam int FW    = rowm_pkg::FIELD_W;
   localparam int SUM_W = 2 * FW;
   localparam int CNT_W = $clog2(SUM_W);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_ACC  = 4'b0010,
      ST_DIV  = 4'b0100,
      ST_FIN  = 4'b1000
   } state_type;

   state_type                 state_ff, state_in;

   // Accumulators.
   logic signed [SUM_W-1:0]   sum_ff, sum_in;
   logic [FW:0]               total_ff, total_in;
   logic [FW-1:0]             bins_ff, bins_in;

   // Product register between multiply and accumulate.
   logic signed [SUM_W-1:0]   prod_ff, prod_in;
   logic signed [SUM_W:0]     prod_full;

   // Divider registers: the dividend shifts out as the quotient shifts in.
   logic [SUM_W-1:0]          div_ff, div_in;
   logic [FW:0]               rem_ff, rem_in;
   logic [FW:0]               len_ff, len_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic                      neg_ff, neg_in;
   logic                      bad_ff, bad_in;
   logic [FW+1:0]             trial;
   logic                      trial_ge;

   // Result register.
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [FW-1:0]             mean_ff, mean_in;
   logic [FW-1:0]             covered_ff, covered_in;
   logic [FW-1:0]             count_ff, count_in;
   logic                      err_ff, err_in;

   logic [FW+1:0]             total_sum;
   logic signed [SUM_W:0]     acc_sum;
   logic                      acc_ovf;
   logic                      out_free;
   logic                      q_ovf_pos;
   logic                      q_ovf_neg;

   // Signed overlap times score; the magnitude stays below two to the 63.
   always_comb begin
      prod_full = $signed({1'b0, head.amount}) * head.score;
   end

   // Saturating 64-bit accumulate.
   always_comb begin
      acc_sum = (SUM_W+1)'(sum_ff) + (SUM_W+1)'(prod_ff);
      acc_ovf = (sum_ff[SUM_W-1] == prod_ff[SUM_W-1]) &&
                (acc_sum[SUM_W-1] != sum_ff[SUM_W-1]);
   end

   // One restoring divide step.
   always_comb begin
      trial    = {rem_ff, div_ff[SUM_W-1]};
      trial_ge = (trial >= (FW+2)'(len_ff));
   end

   // Saturation of the quotient to the signed 32-bit range.
   always_comb begin
      q_ovf_pos = |div_ff[SUM_W-1:FW-1];
      q_ovf_neg = (|div_ff[SUM_W-1:FW]) || (div_ff[FW-1] && (|div_ff[FW-2:0]));
   end

   always_comb begin
      total_sum = (FW+2)'(total_ff) + (FW+2)'(head.amount);
      out_free  = !rsp_valid_ff || rsp_tready;
      pop       = (state_ff == ST_IDLE) && !empty;
   end

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      sum_in       = sum_ff;
      total_in     = total_ff;
      bins_in      = bins_ff;
      prod_in      = prod_ff;
      div_in       = div_ff;
      rem_in       = rem_ff;
      len_in       = len_ff;
      cnt_in       = cnt_ff;
      neg_in       = neg_ff;
      bad_in       = bad_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      mean_in      = mean_ff;
      covered_in   = covered_ff;
      count_in     = count_ff;
      err_in       = err_ff;
      case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               case (head.kind)
                  rowm_pkg::KIND_START: begin
                     sum_in   = '0;
                     total_in = '0;
                     bins_in  = '0;
                  end
                  rowm_pkg::KIND_BIN: begin
                     prod_in  = head.skip ? '0 : prod_full[SUM_W-1:0];
                     total_in = total_sum[FW+1] ? '1 : total_sum[FW:0];
                     bins_in  = (bins_ff == '1) ? bins_ff : bins_ff + FW'(1);
                     state_in = ST_ACC;
                  end
                  rowm_pkg::KIND_FINISH: begin
                     len_in   = head.amount;
                     bad_in   = head.bad_frame;
                     neg_in   = sum_ff[SUM_W-1];
                     div_in   = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
                     rem_in   = '0;
                     cnt_in   = '0;
                     state_in = head.bad_frame ? ST_FIN : ST_DIV;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_ACC: begin
            if (acc_ovf) begin
               sum_in = sum_ff[SUM_W-1] ? {1'b1, {(SUM_W-1){1'b0}}} :
                                          {1'b0, {(SUM_W-1){1'b1}}};
            end else begin
               sum_in = acc_sum[SUM_W-1:0];
            end
            state_in = ST_IDLE;
         end
         ST_DIV: begin
            rem_in = trial_ge ? (FW+1)'(trial - (FW+2)'(len_ff)) : trial[FW:0];
            div_in = {div_ff[SUM_W-2:0], trial_ge};
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(SUM_W-1)) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (bad_ff) begin
                  mean_in = '0;
               end else if (neg_ff) begin
                  mean_in = q_ovf_neg ? {1'b1, {(FW-1){1'b0}}} : FW'(-div_ff[FW-1:0]);
               end else begin
                  mean_in = q_ovf_pos ? {1'b0, {(FW-1){1'b1}}} : div_ff[FW-1:0];
               end
               covered_in = total_ff[FW] ? '1 : total_ff[FW-1:0];
               count_in   = bins_ff;
               err_in     = bad_ff || (total_ff > len_ff);
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sum_ff       <= '0;
         total_ff     <= '0;
         bins_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         total_ff     <= total_in;
         bins_ff      <= bins_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      prod_ff    <= prod_in;
      div_ff     <= div_in;
      rem_ff     <= rem_in;
      len_ff     <= len_in;
      cnt_ff     <= cnt_in;
      neg_ff     <= neg_in;
      bad_ff     <= bad_in;
      mean_ff    <= mean_in;
      covered_ff <= covered_in;
      count_ff   <= count_in;
      err_ff     <= err_in;
   end

   always_comb begin
      rsp_tvalid       = rsp_valid_ff;
      rsp_tdata        = {count_ff, covered_ff, mean_ff};
      rsp_tuser        = err_ff;
      status.dividing  = (state_ff == ST_DIV);
      status.finishing = (state_ff == ST_FIN);
   end

endmodule

`default_nettype wire

// ----- sv/region_overlap_weighted_mean_core.sv -----
// Weighted mean of binned scores over one region.
// Input beats arrive on req_*; req_tuser carries the opcode (0 start, 1 bin,
// 2 finish, 3 ignored) and req_tdata carries pos_start, pos_end and bin_score.
// A start sets the closed 1-based frame and clears the sums; a bin adds its
// overlap times score, unless ignore_negative drops a score of zero or less; a
// finish returns one beat on rsp_* with the mean, the covered length and the
// bin count in rsp_tdata and the length error flag in rsp_tuser. csr_wr_en
// with csr_wr_data sets ignore_negative; write it only while the block is idle.
// A beat is registered in the front stage and passes through a two-entry
// queue. The back handles a start in its idle state and an overlapping bin in
// its idle and accumulate states. A finish on a well-ordered frame runs a
// one-bit-per-cycle 64-step divider, and the back takes no new entry until
// the finish has put its result in the result register.
// Reset empties the stage, the queue and the result register and clears the
// frame, the sums and ignore_negative. When rsp_tready is low the result
// waits in its register; the back keeps working until the next finish, and
// then the queue and the front fill and req_tready drops.
`default_nettype none

module region_overlap_weighted_mean_core #(
   parameter int POSITION_BITS = rowm_pkg::POSITION_BITS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [95:0] req_tdata,    // pos_start, pos_end, bin_score
   input  wire logic [1:0]  req_tuser,    // opcode
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [95:0]      rsp_tdata,    // mean_score, covered_length, bin_count
   output logic             rsp_tuser,    // length_error
   input  wire logic        csr_wr_en,
   input  wire logic        csr_wr_data
);

   logic                      ignore_negative_ff;
   logic                      q_push;
   logic                      q_full;
   logic                      q_pop;
   logic                      q_empty;
   rowm_pkg::entry_type       q_entry;
   rowm_pkg::entry_type       q_head;
   rowm_pkg::back_status_type back_status;

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         ignore_negative_ff <= 1'b0;
      end else if (csr_wr_en) begin
         ignore_negative_ff <= csr_wr_data;
      end
   end

   rowm_front #(
      .POSITION_BITS(POSITION_BITS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .ignore_negative (ignore_negative_ff),
      .q_push          (q_push),
      .q_entry         (q_entry),
      .q_full          (q_full)
   );

   rowm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head       (q_head),
      .empty      (q_empty)
   );

   rowm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (q_head),
      .empty      (q_empty),
      .pop        (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .status     (back_status)
   );

   // A new result only ever comes out of the finishing step.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(back_status.finishing))
      else $error("result appeared without a finish");

   // The front never pushes into a full queue.
   assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("push into full queue");

   // The back takes no work while the divider runs.
   assert property (@(posedge clock) disable iff (reset)
      back_status.dividing |-> !q_pop)
      else $error("queue popped during divide");

endmodule

`default_nettype wire

// ----- tb/region_overlap_weighted_mean_checker.sv -----
`timescale 1ns / 1ps

module region_overlap_weighted_mean_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [95:0] req_tdata,    // pos_start, pos_end, bin_score
   input  wire logic [1:0]  req_tuser,    // opcode
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [95:0] rsp_tdata,    // mean_score, covered_length, bin_count
   input  wire logic        rsp_tuser,    // length_error
   input  wire logic        csr_wr_en,
   input  wire logic        csr_wr_data,
   output int               mismatch_count,
   output int               expected_left,
   output int               beats_taken,
   output int               summaries_seen
);

   // One region summary as it leaves the block.
   typedef struct packed {
      logic signed [31:0] mean_score;
      logic [31:0]        covered_length;
      logic [31:0]        bin_count;
      logic               length_error;
   } region_summary_type;

   localparam logic signed [65:0] SUM_HI  = 66'sh0_7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [65:0] SUM_LO  = -SUM_HI - 66'sd1;
   localparam logic signed [65:0] MEAN_HI = 66'sh7FFF_FFFF;
   localparam logic signed [65:0] MEAN_LO = -MEAN_HI - 66'sd1;
   localparam int                 SHOWN_MISMATCHES = 10;

   // Predicted frame, sums and setting of the block.
   logic [31:0]        frame_first;
   logic [31:0]        frame_last;
   logic signed [63:0] weighted_sum;
   logic [32:0]        bases_total;
   logic [31:0]        bins_hit;
   logic               drop_nonpositive;

   region_summary_type summary_expect_q[$];
   int                 fails;
   int                 beats;
   int                 summaries;

   always @(posedge clock) begin : track
      rowm_pkg::opcode_type op;
      logic [31:0]        pos_a;
      logic [31:0]        pos_b;
      logic signed [31:0] score;
      logic [32:0]        lo;
      logic [32:0]        hi;
      logic [32:0]        overlap;
      logic [33:0]        new_total;
      logic [32:0]        frame_len;
      logic signed [65:0] product;
      logic signed [65:0] wide_sum;
      logic signed [65:0] quotient;
      region_summary_type want;
      region_summary_type got;

      if (reset) begin
         frame_first      = '0;
         frame_last       = '0;
         weighted_sum     = '0;
         bases_total      = '0;
         bins_hit         = '0;
         drop_nonpositive = 1'b0;
         summary_expect_q.delete();
      end else begin
         // Predict the effect of an accepted request beat.
         if (req_tvalid && req_tready) begin
            beats++;
            op    = rowm_pkg::opcode_type'(req_tuser);
            pos_a = req_tdata[31:0];
            pos_b = req_tdata[63:32];
            score = req_tdata[95:64];
            case (op)
               rowm_pkg::OP_START: begin
                  frame_first  = pos_a;
                  frame_last   = pos_b;
                  weighted_sum = '0;
                  bases_total  = '0;
                  bins_hit     = '0;
               end
               rowm_pkg::OP_BIN: begin
                  // The bin covers 1-based bases pos_a+1 .. pos_b; clip to the frame.
                  lo = {1'b0, pos_a} + 33'd1;
                  hi = {1'b0, pos_b};
                  if (lo < {1'b0, frame_first}) lo = {1'b0, frame_first};
                  if (hi > {1'b0, frame_last}) hi = {1'b0, frame_last};
                  if (hi >= lo) begin
                     overlap = hi - lo + 33'd1;
                     // The overlap stays below two to the 32, so times a 32-bit score it always
                     // fits 64 bits, and only the running sum needs clamping.
                     if (!(drop_nonpositive && score <= 0)) begin
                        product  = $signed({1'b0, overlap}) * score;
                        wide_sum = product + weighted_sum;
                        if (wide_sum > SUM_HI) wide_sum = SUM_HI;
                        if (wide_sum < SUM_LO) wide_sum = SUM_LO;
                        weighted_sum = wide_sum[63:0];
                     end
                     new_total   = {1'b0, bases_total} + {1'b0, overlap};
                     bases_total = new_total[33] ? '1 : new_total[32:0];
                     if (bins_hit != '1) bins_hit++;
                  end
               end
               rowm_pkg::OP_FINISH: begin
                  want.covered_length = bases_total[32] ? '1 : bases_total[31:0];
                  want.bin_count      = bins_hit;
                  if (frame_last < frame_first) begin
                     want.mean_score   = '0;
                     want.length_error = 1'b1;
                  end else begin
                     frame_len = {1'b0, frame_last} - {1'b0, frame_first} + 33'd1;
                     quotient  = weighted_sum / $signed({1'b0, frame_len});
                     if (quotient > MEAN_HI) quotient = MEAN_HI;
                     if (quotient < MEAN_LO) quotient = MEAN_LO;
                     want.mean_score   = quotient[31:0];
                     want.length_error = bases_total > frame_len;
                  end
                  summary_expect_q.insert(summary_expect_q.size(), want);
               end
               default: ;
            endcase
         end

         // Compare a delivered summary with the oldest prediction.
         if (rsp_tvalid && rsp_tready) begin
            summaries++;
            got.mean_score     = rsp_tdata[31:0];
            got.covered_length = rsp_tdata[63:32];
            got.bin_count      = rsp_tdata[95:64];
            got.length_error   = rsp_tuser;
            if (summary_expect_q.size() == 0) begin
               fails++;
               if (fails <= SHOWN_MISMATCHES)
                  $display("unexpected summary beat: mean %h covered %h bins %h error %b",
                           got.mean_score, got.covered_length, got.bin_count,
                           got.length_error);
            end else begin
               want = summary_expect_q.pop_front();
               if (got != want) begin
                  fails++;
                  if (fails <= SHOWN_MISMATCHES)
                     $display({"summary mismatch: mean %h/%h covered %h/%h bins %h/%h ",
                               "error %b/%b (expected/actual)"},
                              want.mean_score, got.mean_score,
                              want.covered_length, got.covered_length,
                              want.bin_count, got.bin_count,
                              want.length_error, got.length_error);
               end
            end
         end

         if (csr_wr_en) drop_nonpositive = csr_wr_data;
      end

      mismatch_count <= fails;
      expected_left  <= summary_expect_q.size();
      beats_taken    <= beats;
      summaries_seen <= summaries;
   end

endmodule

// ----- tb/region_overlap_weighted_mean_core_tb.sv -----
`timescale 1ns / 1ps

module region_overlap_weighted_mean_core_tb;

   localparam logic [1:0] OP_UNUSED     = 2'd3;
   localparam int         CYCLE_LIMIT   = 500000;
   localparam int         SETTLE_CYCLES = 100;
   localparam int         HOLD_CYCLES   = 400;
   localparam int         PHASE_BEATS   = 150;
   localparam int         PHASES        = 8;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [95:0] req_tdata   = '0;    // pos_start, pos_end, bin_score
   logic [1:0]  req_tuser   = '0;    // opcode
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [95:0] rsp_tdata;           // mean_score, covered_length, bin_count
   logic        rsp_tuser;           // length_error
   logic        csr_wr_en   = 1'b0;
   logic        csr_wr_data = 1'b0;

   int mismatch_count;
   int expected_left;
   int beats_taken;
   int summaries_seen;

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_requests = 0;
   int cycle_count   = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   region_overlap_weighted_mean_core u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   region_overlap_weighted_mean_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .mismatch_count (mismatch_count),
      .expected_left  (expected_left),
      .beats_taken    (beats_taken),
      .summaries_seen (summaries_seen)
   );

   // Run limit in case the block hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d summaries outstanding",
                  cycle_count, expected_left);
         $display("status: fail");
         $finish;
      end
   end

   // Result side: random stalls, plus a long hold-off whenever one is requested.
   initial begin : receiver
      int holds_served;
      holds_served = 0;
      forever begin
         @(posedge clock);
         if (holds_served != hold_requests) begin
            holds_served = hold_requests;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_tready <= (rsp_stall_pct == 0) || ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Offer one request beat and wait until the block takes it. Valid stays high
   // afterwards so that back-to-back beats need no second assignment.
   task automatic send_beat(input logic [1:0] op, input logic [31:0] pos_a,
                            input logic [31:0] pos_b, input logic [31:0] score);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {score, pos_b, pos_a};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Stop offering and wait until every predicted summary has come back.
   task automatic drain_summaries();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_left != 0) @(posedge clock);
   endtask

   task automatic write_ignore_negative(input logic value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Scores lean toward zero and the extremes, the rest spread over all bits.
   function automatic logic [31:0] pick_score();
      case ($urandom_range(9))
         0: return 32'h0000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h8000_0000;
         3, 4: return 32'($urandom_range(32'h3_FFFF)) - 32'h2_0000;
         default: return $urandom;
      endcase
   endfunction

   // One region: a start, bins scattered around the frame, then usually a
   // finish. Now and then noise beats come first, or the finish is dropped or sent twice.
   task automatic run_region();
      logic [31:0] first;
      logic [31:0] span;
      logic [31:0] last;
      logic [31:0] pos_a;
      logic [31:0] pos_b;
      int          reach;
      int          offset;
      int          nbins;

      case ($urandom_range(15))
         0: send_beat(OP_UNUSED, $urandom, $urandom, $urandom);
         1: send_beat(rowm_pkg::OP_BIN, $urandom, $urandom, pick_score());
         2: begin
            send_beat(rowm_pkg::OP_START, $urandom_range(1, 1000),
                      $urandom_range(1, 1000), $urandom);
            send_beat(rowm_pkg::OP_BIN, $urandom_range(0, 1000),
                      $urandom_range(0, 1000), pick_score());
         end
         default: ;
      endcase

      case ($urandom_range(9))
         0: first = $urandom;
         1: first = 32'hFFFF_FFFF - $urandom_range(300);
         2: first = $urandom_range(3);
         default: first = $urandom_range(1, 100000);
      endcase
      span = ($urandom_range(19) == 0) ? $urandom : $urandom_range(200);
      last = first + span;
      if ($urandom_range(15) == 0) last = first - 32'd1 - $urandom_range(50);
      send_beat(rowm_pkg::OP_START, first, last, $urandom);

      reach = (span > 200) ? 200 : int'(span);
      nbins = $urandom_range(12);
      repeat (nbins) begin
         if ($urandom_range(9) == 0) begin
            pos_a = $urandom;
            pos_b = $urandom;
         end else begin
            offset = int'($urandom_range(0, reach + 40)) - 20;
            pos_a  = first - 32'd1 + 32'(offset);
            pos_b  = pos_a + $urandom_range(60);
            if ($urandom_range(19) == 0) pos_b = pos_a + $urandom;
            if ($urandom_range(11) == 0) pos_b = pos_a - $urandom_range(1, 5);
         end
         send_beat(rowm_pkg::OP_BIN, pos_a, pos_b, pick_score());
      end

      if ($urandom_range(11) != 0) begin
         send_beat(rowm_pkg::OP_FINISH, $urandom, $urandom, $urandom);
         if ($urandom_range(7) == 0)
            send_beat(rowm_pkg::OP_FINISH, $urandom, $urandom, $urandom);
      end
   endtask

   initial begin : stimulus
      int  phase;
      int  phase_goal;
      int  settings_used;
      bit  paused;

      settings_used = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_ignore_negative(1'b0);
      settings_used++;

      // Directed beats. A bin and a finish before any start see the reset frame.
      send_beat(rowm_pkg::OP_BIN, 32'd0, 32'd10, 32'h0001_0000);
      send_beat(rowm_pkg::OP_FINISH, 32'd0, 32'd0, 32'd0);
      send_beat(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      // Widest frames with full-length bins drive the sum into both clamps.
      send_beat(rowm_pkg::OP_START, 32'd1, 32'hFFFF_FFFF, 32'h5A5A_A5A5);
      send_beat(rowm_pkg::OP_BIN, 32'd0, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
      send_beat(rowm_pkg::OP_BIN, 32'd0, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
      send_beat(rowm_pkg::OP_BIN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1);
      send_beat(rowm_pkg::OP_FINISH, 32'hA5A5_5A5A, 32'h0, 32'h7FFF_FFFF);
      send_beat(rowm_pkg::OP_START, 32'd0, 32'hFFFF_FFFF, 32'd0);
      send_beat(rowm_pkg::OP_BIN, 32'd0, 32'hFFFF_FFFF, 32'h8000_0000);
      send_beat(rowm_pkg::OP_BIN, 32'd0, 32'hFFFF_FFFF, 32'h8000_0000);
      send_beat(rowm_pkg::OP_FINISH, 32'd0, 32'd0, 32'h8000_0000);
      // A frame whose last base comes before its first.
      send_beat(rowm_pkg::OP_START, 32'd100, 32'd50, 32'd0);
      send_beat(rowm_pkg::OP_BIN, 32'd40, 32'd120, 32'h0001_0000);
      send_beat(rowm_pkg::OP_FINISH, 32'd0, 32'd0, 32'd0);
      // Frame 11..20: empty, reversed, covering, partial, inner and adjacent bins.
      send_beat(rowm_pkg::OP_START, 32'd11, 32'd20, 32'hFFFF_FFFF);
      send_beat(rowm_pkg::OP_BIN, 32'd15, 32'd15, 32'h0001_0000);
      send_beat(rowm_pkg::OP_BIN, 32'd18, 32'd12, 32'h0001_0000);
      send_beat(rowm_pkg::OP_BIN, 32'd0, 32'd100, 32'hFFFE_8000);
      send_beat(rowm_pkg::OP_BIN, 32'd5, 32'd12, 32'h0003_0000);
      send_beat(rowm_pkg::OP_BIN, 32'd18, 32'd30, 32'd0);
      send_beat(rowm_pkg::OP_BIN, 32'd12, 32'd15, 32'h7FFF_FFFF);
      send_beat(rowm_pkg::OP_BIN, 32'd20, 32'd25, 32'h0001_0000);
      send_beat(rowm_pkg::OP_BIN, 32'd0, 32'd10, 32'h0001_0000);
      send_beat(rowm_pkg::OP_FINISH, 32'd0, 32'd0, 32'd0);
      send_beat(rowm_pkg::OP_FINISH, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      drain_summaries();
      repeat (SETTLE_CYCLES) @(posedge clock);

      // Random phases: the setting alternates and the idle mix rotates.
      for (phase = 0; phase < PHASES; phase++) begin
         write_ignore_negative(phase % 2 == 0);
         settings_used++;
         case (phase % 4)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 48; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 48; end
            default: begin send_idle_pct = 25; rsp_stall_pct = 25; end
         endcase
         // The receiver holds off while regions keep coming, so the block backs up.
         if (phase == 2) hold_requests <= hold_requests + 1;
         paused     = 1'b0;
         phase_goal = beats_taken + PHASE_BEATS;
         while (beats_taken < phase_goal) begin
            if (phase == 5 && !paused && beats_taken > phase_goal - PHASE_BEATS / 2) begin
               drain_summaries();
               paused = 1'b1;
            end
            run_region();
         end
         drain_summaries();
         repeat (SETTLE_CYCLES) @(posedge clock);
      end

      $display("Covered %0d request beats and %0d region summaries over %0d settings",
               beats_taken, summaries_seen, settings_used);
      $display("of ignore_negative, with idle, stall, long hold-off and drain phases.");
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("%0d summary mismatches", mismatch_count);
         $display("status: fail");
      end
      $finish;
   end

endmodule
